// ----- rtl/gtt_pkg.sv -----
package gtt_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FRAMES_DEF = 64;
  localparam int MAX_COEFS_DEF  = 16;
  localparam int COEF_BITS_DEF  = 16;

  // Fixed field widths
  localparam int FUNC_W    = 2;
  localparam int FIDX_W    = 6;
  localparam int CIDX_W    = 4;
  localparam int THR_W     = 20;
  localparam int NCOEF_W   = 5;
  localparam int NFRM_W    = 7;
  localparam int POS_OUT_W = 6;
  localparam int MEAN_W    = 20;
  localparam int OUT_TDATA_W = 32;

  // Internal state widths
  localparam int PART_W = 21;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 16;
  localparam int DIVN_W = SUM_W + 1;
  localparam int DIVD_W = CNT_W + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_COEFFS    = 2'd1;
  localparam logic [1:0] REG_FRAMES    = 2'd2;

  localparam logic [THR_W-1:0]   THRESHOLD_RST = 20'd25600;
  localparam logic [NCOEF_W-1:0] COEFFS_RST    = 5'd12;
  localparam logic [NFRM_W-1:0]  FRAMES_RST    = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_SAMPLE  = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DEC,
    ST_ADV_WAIT,
    ST_FIN,
    ST_MEAN_FW,
    ST_MEAN_Q,
    ST_MEAN_QW,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTART,
    OP_CAPTURE,
    OP_ACCUM,
    OP_ADVANCE,
    OP_STAY,
    OP_DROP,
    OP_KEEP,
    OP_AVG_ADD,
    OP_MEAN_BASE,
    OP_MEAN_ADDQ,
    OP_MEAN_SET,
    OP_MEAN_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic {
    DIV_FRAME,
    DIV_MEAN
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    logic     div_start;
    div_sel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic has_next;
    logic dc_gt;
    logic dn_gt;
    logic dn_lt_dc;
    logic fc_nz;
    logic den_nz;
    logic last;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/greedy_template_tracker.sv -----
// Greedy template tracker. Load a reference template one coefficient per beat
// (func load), then stream sample vectors one coefficient per beat (func sample)
// with tlast on each vector's final coefficient; func restart clears tracking.
// Each sample vector yields exactly one result beat when its tlast beat is
// processed: the current reference frame, a restart flag, and at the last frame
// the mean distance and a match flag. Load and restart beats are handled in the
// idle state; a sample beat inside a vector does registered dual reads of the
// reference memory, then the distance update. A vector end adds a decision
// state and then up to three divisions on one shared 33-step radix-2 divider
// (frame average on an advance, frame average and final mean at the last frame).
// The input stays ready while a result waits in the output register; the
// next result waits for that register to drain. After reset the reference
// memory holds nothing meaningful until loaded; there is no clearing pass.
module greedy_template_tracker import gtt_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int MAX_COEFS  = MAX_COEFS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF,
  localparam int IN_TDATA_W = ((FIDX_W + CIDX_W + COEF_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // frame_index, coef_index, coef_value
  input  logic [FUNC_W-1:0]      in_tuser,   // func
  input  logic                   in_tlast,   // last_coef
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // matched, restarted, ref_position,
                                             // mean_distance
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CV_LO = FIDX_W + CIDX_W;

  logic [THR_W-1:0]   threshold_r;
  logic [NCOEF_W-1:0] coeffs_r;
  logic [NFRM_W-1:0]  frames_r;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  cmd_t cmd;
  sts_t sts;

  logic                        res_matched;
  logic                        res_restarted;
  logic [POS_OUT_W-1:0]        res_pos;
  logic [MEAN_W-1:0]           res_mean;
  logic [FIDX_W-1:0]           in_frame_index;
  logic [CIDX_W-1:0]           in_coef_index;
  logic signed [COEF_BITS-1:0] in_coef_value;

  // Register file: word addresses, writes complete in the access phase
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      coeffs_r    <= COEFFS_RST;
      frames_r    <= FRAMES_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: threshold_r <= cfg_pwdata[THR_W-1:0];
        REG_COEFFS:    coeffs_r    <= cfg_pwdata[NCOEF_W-1:0];
        REG_FRAMES:    frames_r    <= cfg_pwdata[NFRM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: cfg_prdata = CFG_DATA_W'(threshold_r);
      REG_COEFFS:    cfg_prdata = CFG_DATA_W'(coeffs_r);
      REG_FRAMES:    cfg_prdata = CFG_DATA_W'(frames_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Unpack the input beat
  assign in_frame_index = in_tdata[FIDX_W-1:0];
  assign in_coef_index  = in_tdata[CV_LO-1:FIDX_W];
  assign in_coef_value  = in_tdata[CV_LO+COEF_BITS-1:CV_LO];

  gtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gtt_dpath #(
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_COEFS (MAX_COEFS),
    .COEF_BITS (COEF_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .threshold        (threshold_r),
    .coeffs_in_use    (coeffs_r),
    .frames_in_use    (frames_r),
    .in_frame_index   (in_frame_index),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .in_last_coef     (in_tlast),
    .out_matched      (res_matched),
    .out_restarted    (res_restarted),
    .out_ref_position (res_pos),
    .out_mean_distance(res_mean)
  );

  // Pack the result beat, pad the top bits with zeros
  assign out_tdata = OUT_TDATA_W'({res_mean, res_pos, res_restarted, res_matched});

endmodule

// ----- rtl/gtt_div.sv -----
module gtt_div import gtt_pkg::*; #(
  parameter int NW = DIVN_W,
  parameter int DW = DIVD_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // One restoring step per cycle, quotient bits shift in from the bottom
  always_comb begin
    shifted  = {rem_r, quo_r[NW-1]};
    ge       = shifted >= {1'b0, den_r};
    diff     = shifted - {1'b0, den_r};
    rem_nxt  = ge ? diff[DW-1:0] : shifted[DW-1:0];
    quo_nxt  = {quo_r[NW-2:0], ge};
    cnt_nxt  = cnt_r - 1'b1;
    busy_nxt = busy_r && (cnt_r != CW'(1));
    done_nxt = busy_r && (cnt_r == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW);
    end else begin
      done_r <= done_nxt;
      if (busy_r) begin
        busy_r <= busy_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/gtt_dpath.sv -----
module gtt_dpath import gtt_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int MAX_COEFS  = MAX_COEFS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic [THR_W-1:0]            threshold,
  input  logic [NCOEF_W-1:0]          coeffs_in_use,
  input  logic [NFRM_W-1:0]           frames_in_use,
  input  logic [FIDX_W-1:0]           in_frame_index,
  input  logic [CIDX_W-1:0]           in_coef_index,
  input  logic signed [COEF_BITS-1:0] in_coef_value,
  input  logic                        in_last_coef,
  output logic                        out_matched,
  output logic                        out_restarted,
  output logic [POS_OUT_W-1:0]        out_ref_position,
  output logic [MEAN_W-1:0]           out_mean_distance
);

  localparam int DEPTH  = MAX_FRAMES * MAX_COEFS;
  localparam int AW     = $clog2(DEPTH);
  localparam int FR_LIM = (MAX_FRAMES < 127) ? MAX_FRAMES : 127;
  localparam int POS_W  = $clog2(FR_LIM);
  localparam int MF_W   = $clog2(MAX_FRAMES + 1);
  localparam int FCMP_W = ((MF_W > NFRM_W) ? MF_W : NFRM_W) + 1;
  localparam int EC_W   = 7;
  localparam int AD_W   = COEF_BITS + 1;
  localparam int SW     = ((AD_W > PART_W) ? AD_W : PART_W) + 1;

  logic signed [COEF_BITS-1:0] ref_mem [DEPTH];

  logic [POS_W-1:0]     pos_r;
  logic [PART_W-1:0]    dcp_r, dnp_r;
  logic [SUM_W-1:0]     fs_r, avs_r;
  logic [CNT_W-1:0]     fc_r, avc_r;
  logic [DIVN_W-1:0]    num_r;
  logic [DIVD_W-1:0]    den_r;
  logic signed [COEF_BITS-1:0] x_r, rd_cur_r, rd_nxt_r;
  logic                 last_r, use_r, next_ok_r;
  logic                 restarted_r, matched_r;
  logic [MEAN_W-1:0]    mean_r;
  logic                 o_matched_r, o_restarted_r;
  logic [POS_OUT_W-1:0] o_pos_r;
  logic [MEAN_W-1:0]    o_mean_r;

  logic [EC_W-1:0]      eff_coeffs;
  logic [FCMP_W-1:0]    eff_frames;
  logic                 has_next;
  logic                 coef_used;
  logic                 load_ok;
  logic [31:0]          waddr_full, raddr_cur_full, raddr_nxt_full;
  logic signed [AD_W-1:0] dcur, dnxt;
  logic [AD_W-1:0]      mag_cur, mag_nxt;
  logic [SW-1:0]        sum_cur, sum_nxt;
  logic [SUM_W:0]       fs_add, avs_add, num_add;
  logic [CNT_W:0]       fc_inc, avc_inc;
  logic [POS_W+POS_OUT_W-1:0] pos_ext;
  logic                 div_done;
  logic [DIVN_W-1:0]    div_q;
  logic [DIVN_W-1:0]    div_num;
  logic [DIVD_W-1:0]    div_den;

  // Clamp the configured sizes into the legal range
  always_comb begin
    if (coeffs_in_use == '0) begin
      eff_coeffs = EC_W'(1);
    end else if (EC_W'(coeffs_in_use) > EC_W'(MAX_COEFS)) begin
      eff_coeffs = EC_W'(MAX_COEFS);
    end else begin
      eff_coeffs = EC_W'(coeffs_in_use);
    end
    if (frames_in_use == '0) begin
      eff_frames = FCMP_W'(1);
    end else if (FCMP_W'(frames_in_use) > FCMP_W'(MAX_FRAMES)) begin
      eff_frames = FCMP_W'(MAX_FRAMES);
    end else begin
      eff_frames = FCMP_W'(frames_in_use);
    end
  end

  assign has_next  = (FCMP_W'(pos_r) + FCMP_W'(1)) < eff_frames;
  assign coef_used = EC_W'(in_coef_index) < eff_coeffs;
  assign load_ok   = (32'(in_frame_index) < 32'(MAX_FRAMES)) &&
                     (32'(in_coef_index) < 32'(MAX_COEFS));

  assign waddr_full     = 32'(in_frame_index) * 32'(MAX_COEFS) + 32'(in_coef_index);
  assign raddr_cur_full = 32'(pos_r) * 32'(MAX_COEFS) + 32'(in_coef_index);
  assign raddr_nxt_full = raddr_cur_full + 32'(MAX_COEFS);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && load_ok) begin
      ref_mem[waddr_full[AW-1:0]] <= in_coef_value;
    end
    if (cmd.op == OP_CAPTURE && coef_used) begin
      rd_cur_r <= ref_mem[raddr_cur_full[AW-1:0]];
      if (has_next) begin
        rd_nxt_r <= ref_mem[raddr_nxt_full[AW-1:0]];
      end
    end
  end

  // Absolute differences and saturating partial sums
  always_comb begin
    dcur    = AD_W'(rd_cur_r) - AD_W'(x_r);
    dnxt    = AD_W'(rd_nxt_r) - AD_W'(x_r);
    mag_cur = dcur[AD_W-1] ? AD_W'(-dcur) : AD_W'(dcur);
    mag_nxt = dnxt[AD_W-1] ? AD_W'(-dnxt) : AD_W'(dnxt);
    sum_cur = SW'(dcp_r) + SW'(mag_cur);
    sum_nxt = SW'(dnp_r) + SW'(mag_nxt);
    fs_add  = (SUM_W + 1)'(fs_r) + (SUM_W + 1)'(dcp_r);
    avs_add = (SUM_W + 1)'(avs_r) + (SUM_W + 1)'(div_q[SUM_W-1:0]);
    num_add = (SUM_W + 1)'(avs_r) + (SUM_W + 1)'(div_q[SUM_W-1:0]);
    fc_inc  = (CNT_W + 1)'(fc_r) + (CNT_W + 1)'(1);
    avc_inc = (CNT_W + 1)'(avc_r) + (CNT_W + 1)'(1);
    pos_ext = (POS_W + POS_OUT_W)'(pos_r);
  end

  // Divider operands: running frame average or the final mean
  always_comb begin
    if (cmd.div_sel == DIV_MEAN) begin
      div_num = num_r;
      div_den = den_r;
    end else begin
      div_num = DIVN_W'(fs_r);
      div_den = DIVD_W'(fc_r);
    end
  end

  gtt_div #(
    .NW(DIVN_W),
    .DW(DIVD_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      dcp_r       <= '0;
      dnp_r       <= '0;
      fs_r        <= '0;
      fc_r        <= '0;
      avs_r       <= '0;
      avc_r       <= '0;
      restarted_r <= 1'b0;
      matched_r   <= 1'b0;
      mean_r      <= '0;
    end else begin
      case (cmd.op)
        OP_RESTART, OP_DROP: begin
          pos_r       <= '0;
          dcp_r       <= '0;
          dnp_r       <= '0;
          fs_r        <= '0;
          fc_r        <= '0;
          avs_r       <= '0;
          avc_r       <= '0;
          restarted_r <= (cmd.op == OP_DROP);
          matched_r   <= 1'b0;
          mean_r      <= '0;
        end
        OP_ACCUM: begin
          if (use_r) begin
            dcp_r <= (sum_cur[SW-1:PART_W] != '0) ? '1 : sum_cur[PART_W-1:0];
            if (next_ok_r) begin
              dnp_r <= (sum_nxt[SW-1:PART_W] != '0) ? '1 : sum_nxt[PART_W-1:0];
            end
          end
        end
        OP_ADVANCE: begin
          pos_r       <= pos_r + 1'b1;
          fs_r        <= SUM_W'(dnp_r);
          fc_r        <= CNT_W'(1);
          dcp_r       <= '0;
          dnp_r       <= '0;
          restarted_r <= 1'b0;
        end
        OP_STAY: begin
          fs_r        <= fs_add[SUM_W] ? '1 : fs_add[SUM_W-1:0];
          fc_r        <= fc_inc[CNT_W] ? '1 : fc_inc[CNT_W-1:0];
          dcp_r       <= '0;
          dnp_r       <= '0;
          restarted_r <= 1'b0;
        end
        OP_KEEP: begin
          dcp_r       <= '0;
          dnp_r       <= '0;
          restarted_r <= 1'b0;
        end
        OP_AVG_ADD: begin
          avs_r <= avs_add[SUM_W] ? '1 : avs_add[SUM_W-1:0];
          avc_r <= avc_inc[CNT_W] ? '1 : avc_inc[CNT_W-1:0];
        end
        OP_MEAN_SET: begin
          matched_r <= div_q < DIVN_W'(threshold);
          mean_r    <= (div_q[DIVN_W-1:MEAN_W] != '0) ? '1 : div_q[MEAN_W-1:0];
        end
        OP_MEAN_ZERO: begin
          matched_r <= 1'b0;
          mean_r    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        x_r       <= in_coef_value;
        last_r    <= in_last_coef;
        use_r     <= coef_used;
        next_ok_r <= has_next;
      end
      OP_MEAN_BASE: begin
        num_r <= DIVN_W'(avs_r);
        den_r <= DIVD_W'(avc_r);
      end
      OP_MEAN_ADDQ: begin
        num_r <= num_add;
        den_r <= DIVD_W'(avc_r) + DIVD_W'(1);
      end
      OP_EMIT: begin
        o_matched_r   <= matched_r;
        o_restarted_r <= restarted_r;
        o_pos_r       <= pos_ext[POS_OUT_W-1:0];
        o_mean_r      <= mean_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.has_next = has_next;
    sts.dc_gt    = dcp_r > PART_W'(threshold);
    sts.dn_gt    = dnp_r > PART_W'(threshold);
    sts.dn_lt_dc = dnp_r < dcp_r;
    sts.fc_nz    = fc_r != '0;
    sts.den_nz   = den_r != '0;
    sts.last     = last_r;
    sts.div_done = div_done;
  end

  assign out_matched       = o_matched_r;
  assign out_restarted     = o_restarted_r;
  assign out_ref_position  = o_pos_r;
  assign out_mean_distance = o_mean_r;

endmodule

// ----- rtl/gtt_ctrl.sv -----
module gtt_ctrl import gtt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_FRAME;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (func_t'(in_func))
            FUNC_LOAD:    cmd.op = OP_LOAD;
            FUNC_RESTART: cmd.op = OP_RESTART;
            FUNC_SAMPLE: begin
              cmd.op    = OP_CAPTURE;
              state_nxt = ST_ACC;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_ACC: begin
        cmd.op    = OP_ACCUM;
        state_nxt = sts.last ? ST_DEC : ST_IDLE;
      end
      ST_DEC: begin
        if (sts.has_next) begin
          if (sts.dn_gt && sts.dc_gt) begin
            cmd.op    = OP_DROP;
            state_nxt = ST_EMIT;
          end else if (sts.dn_lt_dc) begin
            cmd.op        = OP_ADVANCE;
            cmd.div_start = sts.fc_nz;
            state_nxt     = sts.fc_nz ? ST_ADV_WAIT : ST_FIN;
          end else begin
            cmd.op    = OP_STAY;
            state_nxt = ST_FIN;
          end
        end else if (sts.dc_gt) begin
          cmd.op    = OP_DROP;
          state_nxt = ST_EMIT;
        end else begin
          cmd.op    = OP_KEEP;
          state_nxt = ST_FIN;
        end
      end
      ST_ADV_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_AVG_ADD;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.has_next) begin
          cmd.op    = OP_MEAN_ZERO;
          state_nxt = ST_EMIT;
        end else if (sts.fc_nz) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_MEAN_FW;
        end else begin
          cmd.op    = OP_MEAN_BASE;
          state_nxt = ST_MEAN_Q;
        end
      end
      ST_MEAN_FW: begin
        if (sts.div_done) begin
          cmd.op    = OP_MEAN_ADDQ;
          state_nxt = ST_MEAN_Q;
        end
      end
      ST_MEAN_Q: begin
        if (sts.den_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_nxt     = ST_MEAN_QW;
        end else begin
          cmd.op    = OP_MEAN_ZERO;
          state_nxt = ST_EMIT;
        end
      end
      ST_MEAN_QW: begin
        cmd.div_sel = DIV_MEAN;
        if (sts.div_done) begin
          cmd.op    = OP_MEAN_SET;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
